// ===== rtl/core/bps_pkg.sv =====
`timescale 1ns / 1ps

package bps_pkg;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    logic        [2:0]  mode;
    logic        [5:0]  bone;
    logic        [11:0] vertex;
    logic        [1:0]  row;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] factor;
  } in_t;

  typedef struct packed {
    logic        [11:0] out_vertex;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] nrm_x;
    logic signed [31:0] nrm_y;
    logic signed [31:0] nrm_z;
    logic        [1:0]  status;
    logic        [12:0] vertex_count;
  } out_t;

  localparam logic [2:0] MODE_ROW    = 3'd0;
  localparam logic [2:0] MODE_BASE   = 3'd1;
  localparam logic [2:0] MODE_EXTRA  = 3'd2;
  localparam logic [2:0] MODE_READ   = 3'd3;
  localparam logic [2:0] MODE_BEGIN  = 3'd4;

  localparam logic [1:0] ROW_TRANSLATION = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_REJECTED = 2'd1;
  localparam logic [1:0] STAT_RANGE    = 2'd2;

  localparam logic       REG_BONE_COUNT = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW_RD,
    ST_MUL,
    ST_ACC,
    ST_SMUL,
    ST_SFIN,
    ST_WRITE,
    ST_RD_OUT
  } state_e;

  typedef struct packed {
    logic rot_we;
    logic trn_we;
    logic re;
  } pal_ctl_t;

  typedef struct packed {
    logic pos_we;
    logic nrm_we;
    logic re;
  } vst_ctl_t;

endpackage

// ===== rtl/core/bps_mac.sv =====
`timescale 1ns / 1ps

module bps_mac (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [31:0] q_o
);

  logic signed [63:0] prod_q;
  logic        [47:0] sh;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  // floor shift by 16, then clamp to 32 bits
  assign sh = prod_q[63:16];

  always_comb begin
    if ((&sh[47:31]) || !(|sh[47:31])) begin
      q_o = sh[31:0];
    end else if (sh[47]) begin
      q_o = 32'sh8000_0000;
    end else begin
      q_o = 32'sh7fff_ffff;
    end
  end

endmodule

// ===== rtl/core/bps_palette.sv =====
`timescale 1ns / 1ps

module bps_palette #(
  parameter int Bones = 64,
  localparam int RotDepth = Bones * 3,
  localparam int RA = $clog2(RotDepth),
  localparam int TA = (Bones > 1) ? $clog2(Bones) : 1
) (
  input  logic              clk_i,
  input  bps_pkg::pal_ctl_t ctl_i,
  input  logic [RA-1:0]     rot_waddr_i,
  input  logic [TA-1:0]     trn_waddr_i,
  input  bps_pkg::vec3_t    wdata_i,
  input  logic [RA-1:0]     rot_raddr_i,
  input  logic [TA-1:0]     trn_raddr_i,
  output bps_pkg::vec3_t    rot_o,
  output bps_pkg::vec3_t    trn_o
);

  bps_pkg::vec3_t rot_mem [RotDepth];
  bps_pkg::vec3_t trn_mem [Bones];
  bps_pkg::vec3_t rot_q;
  bps_pkg::vec3_t trn_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.rot_we) begin
      rot_mem[rot_waddr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rot_q <= rot_mem[rot_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.trn_we) begin
      trn_mem[trn_waddr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      trn_q <= trn_mem[trn_raddr_i];
    end
  end

  assign rot_o = rot_q;
  assign trn_o = trn_q;

endmodule

// ===== rtl/core/bps_vstore.sv =====
`timescale 1ns / 1ps

module bps_vstore #(
  parameter int Verts = 4096,
  localparam int VA = $clog2(Verts)
) (
  input  logic              clk_i,
  input  bps_pkg::vst_ctl_t ctl_i,
  input  logic [VA-1:0]     waddr_i,
  input  bps_pkg::vec3_t    pos_i,
  input  bps_pkg::vec3_t    nrm_i,
  input  logic [VA-1:0]     raddr_i,
  output bps_pkg::vec3_t    pos_o,
  output bps_pkg::vec3_t    nrm_o
);

  bps_pkg::vec3_t pos_mem [Verts];
  bps_pkg::vec3_t nrm_mem [Verts];
  bps_pkg::vec3_t pos_q;
  bps_pkg::vec3_t nrm_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.pos_we) begin
      pos_mem[waddr_i] <= pos_i;
    end
    if (ctl_i.re) begin
      pos_q <= pos_mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.nrm_we) begin
      nrm_mem[waddr_i] <= nrm_i;
    end
    if (ctl_i.re) begin
      nrm_q <= nrm_mem[raddr_i];
    end
  end

  assign pos_o = pos_q;
  assign nrm_o = nrm_q;

endmodule

// ===== rtl/core/bone_palette_skinning_unit.sv =====
`timescale 1ns / 1ps

// Fixed-point (Q16.16) linear blend skinning engine built around one shared
// 32x32 multiplier with a registered product; every product is a multiply
// step then an accumulate step, and the sequencer holds in_ready_o low while an
// item is at work. Palette rows, begin mesh and unused modes finish in idle.
// A base vertex runs three position rows of four products each, three normal
// rows of three products and one store write; an extra influence runs the
// three position rows and a store write; a read fetches the vertex store, then
// waits for the output register to free up. A finished read word sits in the
// output register while the next item is accepted. Palette and vertex stores are
// plain RAMs with no clearing pass: contents are undefined until written.
module bone_palette_skinning_unit #(
  parameter int MAX_VERTICES = 4096,
  parameter int MAX_BONES    = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bps_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bps_pkg::out_t   out_data_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int VA = $clog2(MAX_VERTICES);
  localparam int BT = $clog2(MAX_VERTICES + 1);
  localparam int RA = $clog2(MAX_BONES * 3);
  localparam int TA = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

  bps_pkg::state_e state_q, state_d;
  bps_pkg::in_t    item_q, item_d;
  logic [1:0]      row_q, row_d;
  logic [1:0]      term_q, term_d;
  logic            pass_q, pass_d;
  logic signed [34:0] acc_q, acc_d;
  logic [31:0]     res_q, res_d;
  bps_pkg::vec3_t  pos_q, pos_d;
  bps_pkg::vec3_t  nrm_q, nrm_d;
  logic [BT-1:0]   base_total_q, base_total_d;
  logic            rejected_q, rejected_d;
  logic [6:0]      bone_count_q;
  logic            out_valid_q, out_valid_d;
  bps_pkg::out_t   out_q, out_d;

  bps_pkg::pal_ctl_t pal_ctl;
  bps_pkg::vst_ctl_t vst_ctl;
  bps_pkg::vec3_t    rot_row, trn_row, old_pos, old_nrm, vec_op;
  logic signed [31:0] mac_a, mac_b, mac_q;
  logic              mac_en;
  logic              accept, in_bone_ok;
  logic signed [34:0] sum;
  logic [VA-1:0]     vst_waddr;

  function automatic logic [31:0] sat35(input logic signed [34:0] v);
    if ((&v[34:31]) || !(|v[34:31])) begin
      return v[31:0];
    end else if (v[34]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7fff_ffff;
    end
  endfunction

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == bps_pkg::REG_BONE_COUNT) ? {25'd0, bone_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bone_count_q <= 7'd0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == bps_pkg::REG_BONE_COUNT) begin
      bone_count_q <= pwdata[6:0];
    end
  end

  assign accept       = in_valid_i && in_ready_o;
  assign in_ready_o   = (state_q == bps_pkg::ST_IDLE);
  assign in_bone_ok   = (7'(in_data_i.bone) < bone_count_q) &&
                        (32'(in_data_i.bone) < 32'(MAX_BONES));

  assign vec_op = pass_q ? {item_q.bz, item_q.by, item_q.bx}
                         : {item_q.az, item_q.ay, item_q.ax};

  assign vst_waddr = (item_q.mode == bps_pkg::MODE_BASE) ? VA'(base_total_q)
                                                         : VA'(item_q.vertex);

  bps_palette #(.Bones(MAX_BONES)) u_palette (
    .clk_i       (clk_i),
    .ctl_i       (pal_ctl),
    .rot_waddr_i (RA'(10'(in_data_i.bone) * 10'd3 + 10'(in_data_i.row))),
    .trn_waddr_i (TA'(in_data_i.bone)),
    .wdata_i     ({in_data_i.az, in_data_i.ay, in_data_i.ax}),
    .rot_raddr_i (RA'(10'(item_q.bone) * 10'd3 + 10'(row_q))),
    .trn_raddr_i (TA'(item_q.bone)),
    .rot_o       (rot_row),
    .trn_o       (trn_row)
  );

  bps_vstore #(.Verts(MAX_VERTICES)) u_vstore (
    .clk_i   (clk_i),
    .ctl_i   (vst_ctl),
    .waddr_i (vst_waddr),
    .pos_i   (pos_q),
    .nrm_i   (nrm_q),
    .raddr_i (VA'(in_data_i.vertex)),
    .pos_o   (old_pos),
    .nrm_o   (old_nrm)
  );

  bps_mac u_mac (
    .clk_i (clk_i),
    .en_i  (mac_en),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .q_o   (mac_q)
  );

  always_comb begin
    if (state_q == bps_pkg::ST_SMUL) begin
      mac_a = res_q;
      mac_b = item_q.factor;
    end else begin
      mac_a = rot_row[term_q];
      mac_b = vec_op[term_q];
    end
  end

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    row_d        = row_q;
    term_d       = term_q;
    pass_d       = pass_q;
    acc_d        = acc_q;
    res_d        = res_q;
    pos_d        = pos_q;
    nrm_d        = nrm_q;
    base_total_d = base_total_q;
    rejected_d   = rejected_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    pal_ctl      = '0;
    vst_ctl      = '0;
    mac_en       = 1'b0;
    sum          = acc_q + 35'(mac_q);

    case (state_q)
      bps_pkg::ST_IDLE: begin
        if (accept) begin
          item_d = in_data_i;
          row_d  = 2'd0;
          pass_d = 1'b0;
          case (in_data_i.mode)
            bps_pkg::MODE_ROW: begin
              if (32'(in_data_i.bone) < 32'(MAX_BONES)) begin
                if (in_data_i.row == bps_pkg::ROW_TRANSLATION) begin
                  pal_ctl.trn_we = 1'b1;
                end else begin
                  pal_ctl.rot_we = 1'b1;
                end
              end
            end
            bps_pkg::MODE_BASE: begin
              if (!rejected_q) begin
                if (!in_bone_ok || base_total_q >= BT'(MAX_VERTICES)) begin
                  rejected_d = 1'b1;
                end else begin
                  state_d = bps_pkg::ST_ROW_RD;
                end
              end
            end
            bps_pkg::MODE_EXTRA: begin
              vst_ctl.re = 1'b1;
              if (!rejected_q && in_bone_ok &&
                  32'(in_data_i.vertex) < 32'(base_total_q)) begin
                state_d = bps_pkg::ST_ROW_RD;
              end
            end
            bps_pkg::MODE_READ: begin
              vst_ctl.re = 1'b1;
              state_d    = bps_pkg::ST_RD_OUT;
            end
            bps_pkg::MODE_BEGIN: begin
              base_total_d = '0;
              rejected_d   = 1'b0;
            end
            default: ;
          endcase
        end
      end

      bps_pkg::ST_ROW_RD: begin
        pal_ctl.re = 1'b1;
        acc_d      = '0;
        term_d     = 2'd0;
        state_d    = bps_pkg::ST_MUL;
      end

      bps_pkg::ST_MUL: begin
        mac_en  = 1'b1;
        state_d = bps_pkg::ST_ACC;
      end

      bps_pkg::ST_ACC: begin
        if (term_q == 2'd2) begin
          if (!pass_q) begin
            sum     = sum + 35'($signed(trn_row[row_q]));
            res_d   = sat35(sum);
            state_d = bps_pkg::ST_SMUL;
          end else begin
            nrm_d[row_q] = sat35(sum);
            if (row_q == 2'd2) begin
              state_d = bps_pkg::ST_WRITE;
            end else begin
              row_d   = row_q + 2'd1;
              state_d = bps_pkg::ST_ROW_RD;
            end
          end
        end else begin
          acc_d   = sum;
          term_d  = term_q + 2'd1;
          state_d = bps_pkg::ST_MUL;
        end
      end

      bps_pkg::ST_SMUL: begin
        mac_en  = 1'b1;
        state_d = bps_pkg::ST_SFIN;
      end

      bps_pkg::ST_SFIN: begin
        if (item_q.mode == bps_pkg::MODE_BASE) begin
          pos_d[row_q] = mac_q;
        end else begin
          pos_d[row_q] = sat35(35'($signed(old_pos[row_q])) + 35'(mac_q));
        end
        if (row_q == 2'd2) begin
          if (item_q.mode == bps_pkg::MODE_BASE) begin
            // advance to the normal pass
            pass_d  = 1'b1;
            row_d   = 2'd0;
            state_d = bps_pkg::ST_ROW_RD;
          end else begin
            state_d = bps_pkg::ST_WRITE;
          end
        end else begin
          row_d   = row_q + 2'd1;
          state_d = bps_pkg::ST_ROW_RD;
        end
      end

      bps_pkg::ST_WRITE: begin
        vst_ctl.pos_we = 1'b1;
        if (item_q.mode == bps_pkg::MODE_BASE) begin
          vst_ctl.nrm_we = 1'b1;
          base_total_d   = base_total_q + BT'(1);
        end
        state_d = bps_pkg::ST_IDLE;
      end

      bps_pkg::ST_RD_OUT: begin
        // hold until the output register frees up
        if (!out_valid_q || out_ready_i) begin
          out_valid_d             = 1'b1;
          out_d                   = '0;
          out_d.out_vertex        = item_q.vertex;
          out_d.vertex_count      = 13'(base_total_q);
          if (rejected_q) begin
            out_d.status = bps_pkg::STAT_REJECTED;
          end else if (32'(item_q.vertex) >= 32'(base_total_q)) begin
            out_d.status = bps_pkg::STAT_RANGE;
          end else begin
            out_d.status = bps_pkg::STAT_OK;
            out_d.pos_x  = old_pos[0];
            out_d.pos_y  = old_pos[1];
            out_d.pos_z  = old_pos[2];
            out_d.nrm_x  = old_nrm[0];
            out_d.nrm_y  = old_nrm[1];
            out_d.nrm_z  = old_nrm[2];
          end
          state_d = bps_pkg::ST_IDLE;
        end
      end

      default: state_d = bps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bps_pkg::ST_IDLE;
      base_total_q <= '0;
      rejected_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      row_q        <= 2'd0;
      term_q       <= 2'd0;
      pass_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      base_total_q <= base_total_d;
      rejected_q   <= rejected_d;
      out_valid_q  <= out_valid_d;
      row_q        <= row_d;
      term_q       <= term_d;
      pass_q       <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
    pos_q  <= pos_d;
    nrm_q  <= nrm_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== dv/bps_checker.sv =====
`timescale 1ns / 1ps

module bps_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  bps_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  bps_pkg::out_t out_data_i,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  input  logic          pready,
  output int            errors_o,
  output int            pending_o
);

  localparam int NUM_BONES = 64;
  localparam int NUM_VERTS = 4096;

  logic signed [31:0] rot_mem [0:NUM_BONES*9-1];
  logic signed [31:0] trn_mem [0:NUM_BONES*3-1];
  logic signed [31:0] pos_mem [0:NUM_VERTS*3-1];
  logic signed [31:0] nrm_mem [0:NUM_VERTS*3-1];
  int unsigned        vtx_total;
  bit                 rejected;
  int unsigned        bone_limit;
  bps_pkg::out_t      reads_due[$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor shift of the full product, then clamp
  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b;
    return clamp32(p >>> 16);
  endfunction

  function automatic void xform(input int b, input longint v[3], input bit add_t,
                                output longint o[3]);
    longint acc;
    for (int i = 0; i < 3; i++) begin
      acc = fx_mul(rot_mem[b*9+i*3], v[0]) + fx_mul(rot_mem[b*9+i*3+1], v[1])
          + fx_mul(rot_mem[b*9+i*3+2], v[2]);
      if (add_t) acc += trn_mem[b*3+i];
      o[i] = clamp32(acc);
    end
  endfunction

  function automatic bit bone_valid(int unsigned b);
    return b < bone_limit && b < NUM_BONES;
  endfunction

  task automatic report_miss(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    errors_o++;
  endtask

  task automatic skin_word(bps_pkg::in_t d);
    longint        a[3], n[3], t[3];
    int            b, v;
    bps_pkg::out_t r;
    a = '{longint'(d.ax), longint'(d.ay), longint'(d.az)};
    n = '{longint'(d.bx), longint'(d.by), longint'(d.bz)};
    b = d.bone;
    v = d.vertex;
    case (d.mode)
      bps_pkg::MODE_ROW: begin
        for (int k = 0; k < 3; k++)
          if (d.row != bps_pkg::ROW_TRANSLATION) rot_mem[b*9+d.row*3+k] = a[k];
          else trn_mem[b*3+k] = a[k];
      end
      bps_pkg::MODE_BASE: begin
        if (!rejected) begin
          if (!bone_valid(b) || vtx_total >= NUM_VERTS) begin
            rejected = 1'b1;
          end else begin
            xform(b, a, 1'b1, t);
            for (int k = 0; k < 3; k++) pos_mem[vtx_total*3+k] = fx_mul(t[k], d.factor);
            xform(b, n, 1'b0, t);
            for (int k = 0; k < 3; k++) nrm_mem[vtx_total*3+k] = t[k];
            vtx_total++;
          end
        end
      end
      bps_pkg::MODE_EXTRA: begin
        if (!rejected && v < vtx_total && bone_valid(b)) begin
          xform(b, a, 1'b1, t);
          for (int k = 0; k < 3; k++)
            pos_mem[v*3+k] = clamp32(longint'(pos_mem[v*3+k]) + fx_mul(d.factor, t[k]));
        end
      end
      bps_pkg::MODE_READ: begin
        r = '0;
        r.out_vertex = d.vertex;
        r.vertex_count = vtx_total;
        if (rejected) r.status = bps_pkg::STAT_REJECTED;
        else if (v >= vtx_total) r.status = bps_pkg::STAT_RANGE;
        else begin
          r.status = bps_pkg::STAT_OK;
          r.pos_x = pos_mem[v*3];
          r.pos_y = pos_mem[v*3+1];
          r.pos_z = pos_mem[v*3+2];
          r.nrm_x = nrm_mem[v*3];
          r.nrm_y = nrm_mem[v*3+1];
          r.nrm_z = nrm_mem[v*3+2];
        end
        reads_due = {reads_due, r};
      end
      bps_pkg::MODE_BEGIN: begin
        vtx_total = 0;
        rejected = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic match_word(bps_pkg::out_t got);
    bps_pkg::out_t w;
    if (reads_due.size() == 0) begin
      $display("%0t: unexpected read word for vertex %0d", $realtime, got.out_vertex);
      errors_o++;
      return;
    end
    w = reads_due.pop_front();
    if (got.out_vertex !== w.out_vertex) report_miss("out_vertex", got.out_vertex, w.out_vertex);
    if (got.pos_x !== w.pos_x) report_miss("pos_x", got.pos_x, w.pos_x);
    if (got.pos_y !== w.pos_y) report_miss("pos_y", got.pos_y, w.pos_y);
    if (got.pos_z !== w.pos_z) report_miss("pos_z", got.pos_z, w.pos_z);
    if (got.nrm_x !== w.nrm_x) report_miss("nrm_x", got.nrm_x, w.nrm_x);
    if (got.nrm_y !== w.nrm_y) report_miss("nrm_y", got.nrm_y, w.nrm_y);
    if (got.nrm_z !== w.nrm_z) report_miss("nrm_z", got.nrm_z, w.nrm_z);
    if (got.status !== w.status) report_miss("status", got.status, w.status);
    if (got.vertex_count !== w.vertex_count)
      report_miss("vertex_count", got.vertex_count, w.vertex_count);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      errors_o   = 0;
      vtx_total  = 0;
      rejected   = 1'b0;
      bone_limit = 0;
      reads_due.delete();
      pending_o  = 0;
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr == {bps_pkg::REG_BONE_COUNT, 2'b00})
        bone_limit = pwdata[6:0];
      if (out_valid_i && out_ready_i) match_word(out_data_i);
      if (in_valid_i && in_ready_i) skin_word(in_data_i);
      pending_o = reads_due.size();
    end
  end

endmodule

// ===== dv/tb_bone_palette_skinning_unit.sv =====
`timescale 1ns / 1ps

module tb_bone_palette_skinning_unit;

  localparam int  SETTLE_CYCLES = 80;
  localparam int  CYCLE_LIMIT   = 3000000;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  bps_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_ready_i;
  bps_pkg::out_t out_data_o;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [2:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;
  int            errors;
  int            pending;
  int            cycles;
  bit            no_idle;
  int            cur_bones;

  bone_palette_skinning_unit i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  bps_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // mostly small Q16.16 values, sometimes anything
  function automatic logic [31:0] rand_q();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return $urandom_range(0, 32'h80000) - 32'h40000;
  endfunction

  function automatic bps_pkg::in_t make_word(logic [2:0] m, int b, int v, int r);
    bps_pkg::in_t d;
    d.mode = m; d.bone = b; d.vertex = v; d.row = r;
    d.ax = rand_q(); d.ay = rand_q(); d.az = rand_q();
    d.bx = rand_q(); d.by = rand_q(); d.bz = rand_q();
    d.factor = rand_q();
    return d;
  endfunction

  task automatic send(bps_pkg::in_t d);
    int  gap;
    bit  rdy;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    forever begin
      @(negedge clk_i) rdy = in_ready_o;
      @(posedge clk_i);
      if (rdy) break;
    end
  endtask

  task automatic go(logic [2:0] m, int b, int v, int r = 0);
    send(make_word(m, b, v, r));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_bones(int n);
    settle();
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {bps_pkg::REG_BONE_COUNT, 2'b00}; pwdata <= n;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    cur_bones = n;
  endtask

  task automatic random_word();
    int           pick, b, v;
    bps_pkg::in_t d;
    pick = $urandom_range(0, 99);
    b = (cur_bones > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, cur_bones - 1)
                                                     : $urandom_range(0, 63);
    v = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 8) : $urandom_range(0, 4095);
    if (pick < 10) go(bps_pkg::MODE_ROW, $urandom_range(0, 63), v, $urandom_range(0, 3));
    else if (pick < 42) go(bps_pkg::MODE_BASE, b, v);
    else if (pick < 67) go(bps_pkg::MODE_EXTRA, b, v);
    else if (pick < 91) go(bps_pkg::MODE_READ, b, v);
    else if (pick < 96) go(bps_pkg::MODE_BEGIN, b, v);
    else begin
      d = make_word(3'($urandom_range(5, 7)), b, v, 0);
      send(d);
    end
  endtask

  // result side: random stall per word
  initial begin
    int  w;
    bit  vld;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      w = no_idle ? 0 : $urandom_range(0, 13);
      if (w > 0) begin
        out_ready_i <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      forever begin
        @(negedge clk_i) vld = out_valid_o;
        @(posedge clk_i);
        if (vld) break;
      end
    end
  end

  initial begin
    bps_pkg::in_t d;
    cycles = 0; no_idle = 1'b0; cur_bones = 0;
    rst_ni = 1'b0; in_valid_i = 1'b0; in_data_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bone count still zero: base vertex rejects the mesh
    go(bps_pkg::MODE_READ, 0, 0);
    go(bps_pkg::MODE_BASE, 0, 0);
    go(bps_pkg::MODE_EXTRA, 0, 0);
    go(bps_pkg::MODE_READ, 0, 0);
    go(bps_pkg::MODE_BEGIN, 0, 0);
    go(bps_pkg::MODE_READ, 0, 4095);

    // load every palette entry so no unwritten bone is ever used
    no_idle = 1'b1;
    for (int b = 0; b < 64; b++)
      for (int r = 0; r < 4; r++) go(bps_pkg::MODE_ROW, b, 0, r);
    no_idle = 1'b0;
    set_bones(64);

    // extremes of the fields
    d = make_word(bps_pkg::MODE_BASE, 63, 0, 0);
    d.ax = 32'h7fffffff; d.ay = 32'h80000000; d.az = 32'hffffffff;
    d.bx = 32'h7fffffff; d.by = 32'h80000000; d.bz = 32'h0;
    d.factor = 32'h80000000;
    send(d);
    d.bone = 0; d.factor = 32'h7fffffff; d.ax = 32'h80000000; d.ay = 32'h7fffffff;
    send(d);
    d.mode = bps_pkg::MODE_EXTRA; d.vertex = 1; d.factor = 32'h7fffffff;
    send(d);
    d.vertex = 0; d.factor = 32'h80000000;
    send(d);
    go(bps_pkg::MODE_EXTRA, 5, 2);
    go(bps_pkg::MODE_EXTRA, 5, 4095);
    go(bps_pkg::MODE_READ, 0, 0);
    go(bps_pkg::MODE_READ, 0, 1);
    go(bps_pkg::MODE_READ, 0, 2);
    go(bps_pkg::MODE_READ, 0, 4095);
    for (int m = 5; m < 8; m++) go(3'(m), 63, 4095, 3);

    // bad bones under a small count
    set_bones(5);
    go(bps_pkg::MODE_BEGIN, 0, 0);
    go(bps_pkg::MODE_BASE, 4, 0);
    go(bps_pkg::MODE_EXTRA, 5, 0);
    go(bps_pkg::MODE_EXTRA, 63, 0);
    go(bps_pkg::MODE_READ, 0, 0);
    go(bps_pkg::MODE_BASE, 63, 0);
    go(bps_pkg::MODE_READ, 0, 0);
    go(bps_pkg::MODE_EXTRA, 0, 0);

    // fill every vertex slot, then overflow
    set_bones(64);
    go(bps_pkg::MODE_BEGIN, 0, 0);
    no_idle = 1'b1;
    for (int i = 0; i < 4096; i++) go(bps_pkg::MODE_BASE, $urandom_range(0, 63), 0);
    no_idle = 1'b0;
    go(bps_pkg::MODE_EXTRA, 7, 4095);
    go(bps_pkg::MODE_READ, 0, 4095);
    go(bps_pkg::MODE_BASE, 1, 0);
    go(bps_pkg::MODE_READ, 0, 4095);
    go(bps_pkg::MODE_BEGIN, 0, 0);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_bones(64);
        1: set_bones(1);
        2: set_bones($urandom_range(2, 63));
        3: set_bones(0);
        default: set_bones(64);
      endcase
      no_idle = (phase == 4);
      for (int i = 0; i < 140; i++) random_word();
    end
    no_idle = 1'b0;

    settle();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
